// ===== design/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// Delimited span scanner package
// Shared types, register codes and constants for the span scanner blocks.
// ----------------------------------------------------------------------------
package dss_pkg;

  // Character handling
  localparam int          CHAR_W     = 8;
  localparam logic [7:0]  QUOTE_CHAR = 8'h22;

  // Fixed widths of the event fields
  localparam int LINE_OUT_W = 16;
  localparam int COL_OUT_W  = 12;
  localparam int MAX_EVENTS = 3;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MARKUP = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLASS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDENT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_STYLE  = 3'd4;

  // Register reset values
  localparam logic [7:0]  ESCAPE_RESET = 8'h5C;
  localparam logic [15:0] MARKUP_RESET = 16'h3E3E;
  localparam logic [15:0] CLASS_RESET  = 16'h5B5D;
  localparam logic [15:0] IDENT_RESET  = 16'h2829;
  localparam logic [15:0] STYLE_RESET  = 16'h7B7D;

  // Event codes
  localparam logic       KIND_OPEN   = 1'b0;
  localparam logic       KIND_CLOSE  = 1'b1;
  localparam logic [1:0] SPAN_MARKUP = 2'd0;
  localparam logic [1:0] SPAN_CLASS  = 2'd1;
  localparam logic [1:0] SPAN_IDENT  = 2'd2;
  localparam logic [1:0] SPAN_STYLE  = 2'd3;

  // Configuration registers as seen by the scanner
  typedef struct packed {
    logic [7:0]  escape_char;
    logic [15:0] markup_delims;
    logic [15:0] class_delims;
    logic [15:0] ident_delims;
    logic [15:0] style_delims;
  } cfg_t;

  // One open or close event
  typedef struct packed {
    logic                 kind;
    logic [1:0]           span;
    logic [COL_OUT_W-1:0] start_col;
    logic [COL_OUT_W-1:0] end_col;
  } event_t;

  // All events caused by one character, sharing one line number
  typedef struct packed {
    logic [LINE_OUT_W-1:0]    line;
    logic [1:0]               count;
    event_t [MAX_EVENTS-1:0]  ev;
  } bundle_t;

  function automatic event_t make_event(input logic kind, input logic [1:0] span,
                                        input logic [COL_OUT_W-1:0] start_col,
                                        input logic [COL_OUT_W-1:0] end_col);
    event_t e;
    e.kind      = kind;
    e.span      = span;
    e.start_col = start_col;
    e.end_col   = end_col;
    return e;
  endfunction

endpackage

// ===== design/delimited_span_scanner.sv =====
// ----------------------------------------------------------------------------
// Delimited span scanner
// Scans text a character at a time and reports markup spans and the class,
// id and style spans inside them as open and close events.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Handshake                      Payload
// s_axis     in         s_axis_tvalid / s_axis_tready  tdata: text_char, tuser: line_begin
// m_axis     out        m_axis_tvalid / m_axis_tready  tdata: line, columns; tuser: kind, type
// cfg        in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One character is accepted per cycle while the event queue has room.
// Each event is sent as its own output word, so up to three words per character on
// the output side; the queue of QUEUE_DEPTH bundles absorbs bursts.
// With the queue and output stage empty, an event passes through a queue entry and
// then the output register before it appears on m_axis.
// Reset is synchronous and returns the control state and the configuration registers
// to their defaults. A stalled output holds its word while input keeps filling the queue.
//
module delimited_span_scanner
  import dss_pkg::*;
#(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 12,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // text_char
  input  logic                   s_axis_tuser,   // line_begin
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [39:0]            m_axis_tdata,   // line_number, start_column, end_column
  output logic [2:0]             m_axis_tuser,   // event_kind, span_type
  output logic                   m_axis_tlast,   // last_event
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  bundle_t push_data, head;
  logic    push, pop, full, not_empty;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escape_char   <= ESCAPE_RESET;
      cfg.markup_delims <= MARKUP_RESET;
      cfg.class_delims  <= CLASS_RESET;
      cfg.ident_delims  <= IDENT_RESET;
      cfg.style_delims  <= STYLE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ESCAPE: cfg.escape_char   <= cfg_data[7:0];
        CFG_MARKUP: cfg.markup_delims <= cfg_data;
        CFG_CLASS:  cfg.class_delims  <= cfg_data;
        CFG_IDENT:  cfg.ident_delims  <= cfg_data;
        CFG_STYLE:  cfg.style_delims  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end: character classification and span state
  dss_front #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_char   (s_axis_tdata),
    .in_begin  (s_axis_tuser),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  // Event queue between the two sides
  dss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .not_empty (not_empty)
  );

  // Back end: one event word per cycle while the output is not stalled
  dss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .not_empty     (not_empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== design/dss_front.sv =====
// ----------------------------------------------------------------------------
// Span scanner front end
// Accepts one character per cycle while the queue is not full, tracks line, column and per-line span
// state, and pushes the events of each character that has any as one bundle.
// ----------------------------------------------------------------------------
module dss_front
  import dss_pkg::*;
#(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_begin,
  input  logic              full,
  output logic              push,
  output bundle_t           push_data
);

  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};

  // Scanner state
  logic                   quoted, markup_open, class_open, ident_open, style_open;
  logic [CHAR_W-1:0]      previous_char;
  logic [COLUMN_BITS-1:0] markup_start, inner_start;
  logic [LINE_BITS-1:0]   line_counter;
  logic [COLUMN_BITS-1:0] column_counter;

  logic                   quoted_next, markup_open_next, class_open_next;
  logic                   ident_open_next, style_open_next;
  logic [COLUMN_BITS-1:0] markup_start_next, inner_start_next;
  logic [LINE_BITS-1:0]   line_counter_next;
  logic [COLUMN_BITS-1:0] column_counter_next;

  // Per-line view after any line start has been applied
  logic                   markup_cur, class_cur, ident_cur, style_cur;
  logic [CHAR_W-1:0]      prev_cur;
  logic [COLUMN_BITS-1:0] mstart_cur, istart_cur, col_cur;
  logic [COL_OUT_W-1:0]   col_out;
  logic                   active, done;
  logic [1:0]             n_ev;
  event_t [MAX_EVENTS-1:0] evs;
  logic                   fire;

  assign in_ready = !full;
  assign fire     = in_valid && !full;

  // Classify the character and build its events
  always_comb begin
    markup_cur = in_begin ? 1'b0 : markup_open;
    class_cur  = in_begin ? 1'b0 : class_open;
    ident_cur  = in_begin ? 1'b0 : ident_open;
    style_cur  = in_begin ? 1'b0 : style_open;
    prev_cur   = in_begin ? '0 : previous_char;
    mstart_cur = in_begin ? '0 : markup_start;
    istart_cur = in_begin ? '0 : inner_start;
    col_cur    = in_begin ? '0 : column_counter;
    col_out    = COL_OUT_W'(col_cur);

    if (in_begin && column_counter != '0 && line_counter != LINE_MAX) begin
      line_counter_next = line_counter + LINE_BITS'(1);
    end else begin
      line_counter_next = line_counter;
    end
    column_counter_next = (col_cur != COL_MAX) ? col_cur + COLUMN_BITS'(1) : col_cur;

    // A quote toggles quoted mode before the skip checks
    quoted_next = (in_begin ? 1'b0 : quoted) ^ (in_char == QUOTE_CHAR);
    active = !((col_cur != '0) && (prev_cur == cfg.escape_char)) && !quoted_next;

    markup_open_next  = markup_cur;
    class_open_next   = class_cur;
    ident_open_next   = ident_cur;
    style_open_next   = style_cur;
    markup_start_next = mstart_cur;
    inner_start_next  = istart_cur;
    evs  = '0;
    n_ev = 2'd0;
    done = 1'b0;

    if (active && in_char == cfg.markup_delims[15:8]) begin
      markup_open_next  = 1'b1;
      markup_start_next = col_cur;
      evs[0] = make_event(KIND_OPEN, SPAN_MARKUP, col_out, '0);
      n_ev   = 2'd1;
    end else if (active && in_char == cfg.markup_delims[7:0]) begin
      markup_open_next = 1'b0;
      evs[0] = make_event(KIND_CLOSE, SPAN_MARKUP, COL_OUT_W'(mstart_cur), col_out);
      n_ev   = 2'd1;
    end else if (active && markup_cur) begin
      // Class span; an open ends the checks, a close does not
      if (in_char == cfg.class_delims[15:8] && !class_cur) begin
        class_open_next  = 1'b1;
        inner_start_next = col_cur;
        evs[n_ev] = make_event(KIND_OPEN, SPAN_CLASS, col_out, '0);
        n_ev = n_ev + 2'd1;
        done = 1'b1;
      end else if (in_char == cfg.class_delims[7:0] && class_cur) begin
        class_open_next = 1'b0;
        evs[n_ev] = make_event(KIND_CLOSE, SPAN_CLASS, COL_OUT_W'(istart_cur), col_out);
        n_ev = n_ev + 2'd1;
      end
      // Id span
      if (!done) begin
        if (in_char == cfg.ident_delims[15:8] && !ident_cur) begin
          ident_open_next  = 1'b1;
          inner_start_next = col_cur;
          evs[n_ev] = make_event(KIND_OPEN, SPAN_IDENT, col_out, '0);
          n_ev = n_ev + 2'd1;
          done = 1'b1;
        end else if (in_char == cfg.ident_delims[7:0] && ident_cur) begin
          ident_open_next = 1'b0;
          evs[n_ev] = make_event(KIND_CLOSE, SPAN_IDENT, COL_OUT_W'(istart_cur), col_out);
          n_ev = n_ev + 2'd1;
        end
      end
      // Style span
      if (!done) begin
        if (in_char == cfg.style_delims[15:8] && !style_cur) begin
          style_open_next  = 1'b1;
          inner_start_next = col_cur;
          evs[n_ev] = make_event(KIND_OPEN, SPAN_STYLE, col_out, '0);
          n_ev = n_ev + 2'd1;
        end else if (in_char == cfg.style_delims[7:0] && style_cur) begin
          style_open_next = 1'b0;
          evs[n_ev] = make_event(KIND_CLOSE, SPAN_STYLE, COL_OUT_W'(istart_cur), col_out);
          n_ev = n_ev + 2'd1;
        end
      end
    end
  end

  // Characters without events are not queued
  assign push            = fire && (n_ev != 2'd0);
  assign push_data.line  = LINE_OUT_W'(line_counter_next);
  assign push_data.count = n_ev;
  assign push_data.ev    = evs;

  // State update on each accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      quoted         <= 1'b0;
      markup_open    <= 1'b0;
      class_open     <= 1'b0;
      ident_open     <= 1'b0;
      style_open     <= 1'b0;
      previous_char  <= '0;
      markup_start   <= '0;
      inner_start    <= '0;
      line_counter   <= '0;
      column_counter <= '0;
    end else if (fire) begin
      quoted         <= quoted_next;
      markup_open    <= markup_open_next;
      class_open     <= class_open_next;
      ident_open     <= ident_open_next;
      style_open     <= style_open_next;
      previous_char  <= in_char;
      markup_start   <= markup_start_next;
      inner_start    <= inner_start_next;
      line_counter   <= line_counter_next;
      column_counter <= column_counter_next;
    end
  end

`ifndef SYNTH
  // A line start always leaves the next character at column one.
  assert property (@(posedge clk) disable iff (rst)
    fire && in_begin |=> column_counter == COLUMN_BITS'(1))
    else $error("column not restarted after line start");
`endif

endmodule

// ===== design/dss_queue.sv =====
// ----------------------------------------------------------------------------
// Span scanner event queue
// Short first-in first-out store of event bundles between front and back.
// ----------------------------------------------------------------------------
module dss_queue
  import dss_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    full,
  output logic    not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = store[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("write into a full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("read from an empty queue");
`endif

endmodule

// ===== design/dss_back.sv =====
// ----------------------------------------------------------------------------
// Span scanner back end
// Sends the events of each queued bundle one word per cycle, while the output is not stalled,
// through a registered output stage.
// ----------------------------------------------------------------------------
module dss_back
  import dss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  bundle_t     head,
  input  logic        not_empty,
  output logic        pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // line_number, start_column, end_column
  output logic [2:0]  m_axis_tuser,  // event_kind, span_type
  output logic        m_axis_tlast   // last_event
);

  logic                  out_valid;
  event_t                out_event;
  logic [LINE_OUT_W-1:0] out_line;
  logic                  out_last;
  logic [1:0]            sub;
  logic                  load, take, bundle_end;

  // The output register takes a new word when empty or being drained
  assign load       = !out_valid || m_axis_tready;
  assign take       = load && not_empty;
  assign bundle_end = (sub == head.count - 2'd1);
  assign pop        = take && bundle_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= not_empty;
      end
      if (take) begin
        sub <= bundle_end ? 2'd0 : sub + 2'd1;
      end
    end
  end

  // Payload of the output word
  always_ff @(posedge clk) begin
    if (take) begin
      out_event <= head.ev[sub];
      out_line  <= head.line;
      out_last  <= bundle_end;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_event.end_col, out_event.start_col, out_line};
  assign m_axis_tuser  = {out_event.span, out_event.kind};
  assign m_axis_tlast  = out_last;

`ifndef SYNTH
  // Every queued bundle carries at least one event.
  assert property (@(posedge clk) disable iff (rst) not_empty |-> head.count != 2'd0)
    else $error("empty bundle in queue");
  // Retiring a bundle always presents its final event.
  assert property (@(posedge clk) disable iff (rst) pop |=> m_axis_tvalid && m_axis_tlast)
    else $error("bundle retired without its last event");
`endif

endmodule
